FILE: design/space_vector_pwm_duty_core_assert.svh
// Assertion macros shared by the FIFO and back-end design files.
`ifndef SPACE_VECTOR_PWM_DUTY_CORE_ASSERT_SVH
`define SPACE_VECTOR_PWM_DUTY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define SVPWM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("svpwm assertion failed");

`define SVPWM_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("svpwm assertion failed");

`else

`define SVPWM_ASSERT(lbl, prop)

`define SVPWM_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

FILE: design/svpwm_pkg.sv
package svpwm_pkg;

    localparam int T_W = 36;

    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;
    localparam logic [2:0] SEC_6 = 3'd6;

    // round(2^16/sqrt3) and round(2^17/sqrt3)
    localparam logic signed [16:0] INV_SQRT3_Q16     = 17'sd37837;
    localparam logic signed [17:0] TWO_INV_SQRT3_Q16 = 18'sd75674;

    localparam logic signed [T_W-1:0] ONE_Q31    = 36'sh0_8000_0000;
    localparam logic signed [T_W-1:0] ONE_Q32    = 36'sh1_0000_0000;
    localparam logic        [T_W-1:0] ROUND_HALF = 36'h0_0000_8000;
    localparam logic        [16:0]    DUTY_ONE   = 17'h1_0000;

    typedef logic [2:0] sector_t;

    typedef struct packed {
        sector_t            sector;
        logic signed [15:0] alpha;
        logic signed [32:0] b1;
        logic signed [33:0] b2;
    } mid_item_t;

    typedef struct packed {
        logic [16:0] duty_a;
        logic [16:0] duty_b;
        logic [16:0] duty_c;
        sector_t     sector;
        logic        in_range;
    } out_item_t;

endpackage

FILE: design/svpwm_fifo.sv
`include "space_vector_pwm_duty_core_assert.svh"

module svpwm_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    `SVPWM_ASSERT_ALWAYS(a_fifo_reset_empty, !rst_n |=> empty)
    `SVPWM_ASSERT(a_fifo_not_full_and_empty, !(full && empty))
    `SVPWM_ASSERT(a_fifo_count_max, count_reg <= CNT_W'(DEPTH))
    `SVPWM_ASSERT(a_fifo_pop_drains, (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)

endmodule

FILE: design/svpwm_front.sv
module svpwm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic signed [15:0]    vec_alpha,
    input  logic signed [15:0]    vec_beta,
    output logic                  q_push,
    input  logic                  q_full,
    output svpwm_pkg::mid_item_t  q_item
);
    import svpwm_pkg::*;

    logic               valid_reg, valid_next;
    logic               advance;
    logic signed [15:0] alpha_reg;
    logic signed [32:0] b1_reg;
    logic signed [33:0] b2_reg;
    logic signed [32:0] b1_prod;
    logic signed [33:0] b2_prod;
    logic signed [33:0] a_cmp;
    logic signed [33:0] b1_cmp;
    logic signed [33:0] nb1_cmp;
    sector_t            sector_sel;

    // beta/sqrt3 and 2*beta/sqrt3 in Q.16 scale of alpha
    assign b1_prod = 33'(vec_beta) * 33'(INV_SQRT3_Q16);
    assign b2_prod = 34'(vec_beta) * 34'(TWO_INV_SQRT3_Q16);

    assign advance    = !valid_reg || !q_full;
    assign full       = !advance;
    assign valid_next = advance ? push : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            alpha_reg <= vec_alpha;
            b1_reg    <= b1_prod;
            b2_reg    <= b2_prod;
        end
    end

    assign a_cmp   = $signed({{2{alpha_reg[15]}}, alpha_reg, 16'h0000});
    assign b1_cmp  = $signed({b1_reg[32], b1_reg});
    assign nb1_cmp = -b1_cmp;

    // Ties fall to the lower sector in the upper half, to 5 and 6 in the lower half
    always_comb
    begin
        if (!b1_reg[32])
        begin
            if (!alpha_reg[15])
            begin
                sector_sel = (b1_cmp > a_cmp) ? SEC_2 : SEC_1;
            end
            else
            begin
                sector_sel = (nb1_cmp > a_cmp) ? SEC_3 : SEC_2;
            end
        end
        else
        begin
            if (!alpha_reg[15])
            begin
                sector_sel = (nb1_cmp > a_cmp) ? SEC_5 : SEC_6;
            end
            else
            begin
                sector_sel = (b1_cmp > a_cmp) ? SEC_4 : SEC_5;
            end
        end
    end

    assign q_push        = valid_reg && !q_full;
    assign q_item.sector = sector_sel;
    assign q_item.alpha  = alpha_reg;
    assign q_item.b1     = b1_reg;
    assign q_item.b2     = b2_reg;

endmodule

FILE: design/svpwm_back.sv
`include "space_vector_pwm_duty_core_assert.svh"

module svpwm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  svpwm_pkg::mid_item_t  q_item,
    input  logic                  out_full,
    output logic                  out_push,
    output svpwm_pkg::out_item_t  out_item
);
    import svpwm_pkg::*;

    logic                 en;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    sector_t              s1_sector_reg, s2_sector_reg;
    logic signed [T_W-1:0] s1_p_reg, s1_q_reg;
    logic signed [T_W-1:0] p_calc, q_calc;
    logic signed [T_W-1:0] a_w, b1_w, b2_w;
    logic signed [T_W-1:0] lo_sum, pmq_sum, mpq_sum, hi_sum;
    logic signed [T_W-1:0] ta_calc, tb_calc, tc_calc;
    logic signed [T_W-1:0] ta_reg, tb_reg, tc_reg;
    logic [17:0]          ca, cb, cc;

    function automatic logic [17:0] clamp_duty(input logic signed [T_W-1:0] x);
        logic [T_W-1:0] r;
        r = $unsigned(x) + ROUND_HALF;
        if (x[T_W-1])
        begin
            return {1'b0, 17'h0_0000};
        end
        else if (x > ONE_Q32)
        begin
            return {1'b0, DUTY_ONE};
        end
        return {1'b1, r[32:16]};
    endfunction

    // Whole back end holds while the result queue is full
    assign en            = !out_full;
    assign q_pop         = en && !q_empty;
    assign s1_valid_next = en ? q_pop : s1_valid_reg;
    assign s2_valid_next = en ? s1_valid_reg : s2_valid_reg;
    assign out_push      = en && s2_valid_reg;

    assign a_w  = $signed({{4{q_item.alpha[15]}}, q_item.alpha, 16'h0000});
    assign b1_w = $signed({{3{q_item.b1[32]}}, q_item.b1});
    assign b2_w = $signed({{2{q_item.b2[33]}}, q_item.b2});

    // Active-vector times of the two adjacent vectors
    always_comb
    begin
        case (q_item.sector)
            SEC_1:
            begin
                p_calc = a_w - b1_w;
                q_calc = b2_w;
            end
            SEC_2:
            begin
                p_calc = a_w + b1_w;
                q_calc = b1_w - a_w;
            end
            SEC_3:
            begin
                p_calc = b2_w;
                q_calc = -a_w - b1_w;
            end
            SEC_4:
            begin
                p_calc = b1_w - a_w;
                q_calc = -b2_w;
            end
            SEC_5:
            begin
                p_calc = -a_w - b1_w;
                q_calc = a_w - b1_w;
            end
            default:
            begin
                p_calc = -b2_w;
                q_calc = a_w + b1_w;
            end
        endcase
    end

    // Each duty is one of four sums; route them per sector
    assign lo_sum  = ONE_Q31 - s1_p_reg - s1_q_reg;
    assign pmq_sum = ONE_Q31 + s1_p_reg - s1_q_reg;
    assign mpq_sum = ONE_Q31 - s1_p_reg + s1_q_reg;
    assign hi_sum  = ONE_Q31 + s1_p_reg + s1_q_reg;

    always_comb
    begin
        case (s1_sector_reg)
            SEC_1:
            begin
                ta_calc = lo_sum;
                tb_calc = pmq_sum;
                tc_calc = hi_sum;
            end
            SEC_2:
            begin
                ta_calc = mpq_sum;
                tb_calc = lo_sum;
                tc_calc = hi_sum;
            end
            SEC_3:
            begin
                ta_calc = hi_sum;
                tb_calc = lo_sum;
                tc_calc = pmq_sum;
            end
            SEC_4:
            begin
                ta_calc = hi_sum;
                tb_calc = mpq_sum;
                tc_calc = lo_sum;
            end
            SEC_5:
            begin
                ta_calc = pmq_sum;
                tb_calc = hi_sum;
                tc_calc = lo_sum;
            end
            default:
            begin
                ta_calc = lo_sum;
                tb_calc = hi_sum;
                tc_calc = mpq_sum;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_sector_reg <= q_item.sector;
            s1_p_reg      <= p_calc;
            s1_q_reg      <= q_calc;
        end
        if (en && s1_valid_reg)
        begin
            s2_sector_reg <= s1_sector_reg;
            ta_reg        <= ta_calc;
            tb_reg        <= tb_calc;
            tc_reg        <= tc_calc;
        end
    end

    assign ca = clamp_duty(ta_reg);
    assign cb = clamp_duty(tb_reg);
    assign cc = clamp_duty(tc_reg);

    assign out_item.duty_a   = ca[16:0];
    assign out_item.duty_b   = cb[16:0];
    assign out_item.duty_c   = cc[16:0];
    assign out_item.sector   = s2_sector_reg;
    assign out_item.in_range = ca[17] && cb[17] && cc[17];

    `SVPWM_ASSERT(a_back_sector_legal, s2_valid_reg |-> (s2_sector_reg >= SEC_1 && s2_sector_reg <= SEC_6))
    `SVPWM_ASSERT(a_back_s1_to_s2, (en && s1_valid_reg) |=> s2_valid_reg)
    `SVPWM_ASSERT(a_back_clamp_marks, (out_push && !out_item.in_range) |-> (out_item.duty_a == 17'h0_0000 || out_item.duty_a == DUTY_ONE || out_item.duty_b == 17'h0_0000 || out_item.duty_b == DUTY_ONE || out_item.duty_c == 17'h0_0000 || out_item.duty_c == DUTY_ONE))

endmodule

FILE: design/space_vector_pwm_duty_core.sv
// Seven-segment space vector PWM duty core.
// A beat pushed at the input passes the front register, the mid queue, two back stages and the
// result queue before it can be popped. Throughput: one beat per cycle in and out while no
// queue is full; the front multipliers and back adders are pipelined.
// Reset clears the queues and stage valid bits only; no clearing pass is needed.
module space_vector_pwm_duty_core #(
    parameter int unsigned MID_DEPTH = 4,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] vec_alpha,
    input  logic signed [15:0] vec_beta,
    output logic               empty,
    input  logic               pop,
    output logic [16:0]        duty_a,
    output logic [16:0]        duty_b,
    output logic [16:0]        duty_c,
    output logic [2:0]         sector,
    output logic               in_range
);
    import svpwm_pkg::*;

    localparam int unsigned MID_W = $bits(mid_item_t);
    localparam int unsigned OUT_W = $bits(out_item_t);

    logic       mid_push, mid_full, mid_pop, mid_empty;
    mid_item_t  mid_wr, mid_rd;
    logic       res_push, res_full;
    out_item_t  res_wr, res_rd;

    svpwm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .vec_alpha (vec_alpha),
        .vec_beta  (vec_beta),
        .q_push    (mid_push),
        .q_full    (mid_full),
        .q_item    (mid_wr)
    );

    svpwm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .full  (mid_full),
        .wdata (mid_wr),
        .pop   (mid_pop),
        .empty (mid_empty),
        .rdata (mid_rd)
    );

    svpwm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mid_empty),
        .q_pop    (mid_pop),
        .q_item   (mid_rd),
        .out_full (res_full),
        .out_push (res_push),
        .out_item (res_wr)
    );

    svpwm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_wr),
        .pop   (pop),
        .empty (empty),
        .rdata (res_rd)
    );

    assign duty_a   = res_rd.duty_a;
    assign duty_b   = res_rd.duty_b;
    assign duty_c   = res_rd.duty_c;
    assign sector   = res_rd.sector;
    assign in_range = res_rd.in_range;

endmodule
